FILE: src/binomial_coefficient_unit_defines.svh
// Assertion macros for the binomial coefficient unit.
// Included by the top level; needs nothing else.
`ifndef BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define BCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/bcu_pkg.sv
// Shared types and constants of the binomial coefficient unit.
// No dependencies.
`default_nettype none

package bcu_pkg;

   localparam int FIELD_W   = 6;   // n and k
   localparam int COEF_W    = 57;  // result width
   localparam int WORK_W    = 63;  // widest intermediate product
   localparam int COUNT_W   = 6;   // step counter of the shift unit
   localparam int MUL_STEPS = FIELD_W;  // one multiplier bit per step
   localparam int DIV_STEPS = WORK_W;   // one quotient bit per step

   // Largest n computed; above it the overflow flag is raised.
   localparam logic [FIELD_W-1:0] MAX_N = FIELD_W'(60);

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } op_type;

   // Command from the sequencer to the shift unit.
   typedef struct packed {
      logic                go;
      op_type              op;
      logic [WORK_W-1:0]   a;   // multiplicand or dividend
      logic [FIELD_W-1:0]  b;   // multiplier or divisor
   } cmd_type;

endpackage

`default_nettype wire

FILE: src/bcu_shift_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiply, restoring divide.
// Depends on bcu_pkg.
`default_nettype none

module bcu_shift_unit
   import bcu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output logic                    done,
   output logic [WORK_W-1:0]       result
);

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   op_type              op_ff,    op_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [WORK_W-1:0]   a_ff,     a_in;
   logic [FIELD_W-1:0]  b_ff,     b_in;
   logic [WORK_W-1:0]   acc_ff,   acc_in;
   logic [FIELD_W-1:0]  rem_ff,   rem_in;

   logic [FIELD_W:0]    partial;
   logic                fits;

   // Divide step: bring down the next dividend bit, try the subtract.
   assign partial = {rem_ff, acc_ff[WORK_W-1]};
   assign fits    = (partial >= {1'b0, b_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      count_in = count_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      if (cmd.go) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         b_in    = cmd.b;
         rem_in  = '0;
         if (cmd.op == OP_MUL) begin
            a_in     = cmd.a;
            acc_in   = '0;
            count_in = COUNT_W'(MUL_STEPS - 1);
         end else begin
            a_in     = '0;
            acc_in   = cmd.a;
            count_in = COUNT_W'(DIV_STEPS - 1);
         end
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            // add the shifted multiplicand for each set multiplier bit
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[WORK_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[FIELD_W-1:1]};
         end else begin
            // quotient bits shift into the dividend register from the right
            rem_in = fits ? FIELD_W'(partial - {1'b0, b_ff}) : partial[FIELD_W-1:0];
            acc_in = {acc_ff[WORK_W-2:0], fits};
         end
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      count_ff <= count_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

FILE: src/binomial_coefficient_unit.sv
// Binomial coefficient unit: top level with the step sequencer.
// Depends on bcu_pkg, bcu_shift_unit and binomial_coefficient_unit_defines.svh.
//
// Use: present n on req_n_total and k on req_k_chosen and raise start; the
// word is taken at a rising edge where start is high and busy is low. busy
// stays high until the result is out. The result word appears on
// rsp_coefficient and rsp_overflow for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall it and must take it in that cycle.
// After the accepting edge, S_CHECK handles the cases n above MAX_N and k
// above n directly and raises the strobe; otherwise the loop runs m steps,
// m = min(k, n - k). Each step runs one multiply by (n - i), by shift-add,
// and one exact divide by (i + 1), by restoring division, both on the one
// shared shift unit with handoff through the GO and WAIT states, plus a pass
// through loop control. A new word may be started in the strobe cycle.
// Reset is synchronous; it drops busy and any pending result.
`default_nettype none
`include "binomial_coefficient_unit_defines.svh"

module binomial_coefficient_unit
   import bcu_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [FIELD_W-1:0]   req_n_total,
   input  wire logic [FIELD_W-1:0]   req_k_chosen,
   output logic                      rsp_valid,
   output logic [COEF_W-1:0]         rsp_coefficient,
   output logic                      rsp_overflow
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LOOP,
      S_MUL_GO,
      S_MUL_WAIT,
      S_DIV_GO,
      S_DIV_WAIT
   } state_type;

   state_type           state_ff;
   logic [FIELD_W-1:0]  n_ff;
   logic [FIELD_W-1:0]  k_ff;
   logic [FIELD_W-1:0]  m_ff;     // k folded to min(k, n - k)
   logic [FIELD_W-1:0]  i_ff;     // steps done
   logic [COEF_W-1:0]   acc_ff;   // C(n, i)
   logic                rsp_valid_ff;
   logic [COEF_W-1:0]   rsp_coef_ff;
   logic                rsp_ovf_ff;

   cmd_type             cmd;
   logic                unit_done;
   logic [WORK_W-1:0]   unit_result;

   // Shared arithmetic unit
   bcu_shift_unit u_shift_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .done   (unit_done),
      .result (unit_result)
   );

   // Commands to the unit
   always_comb begin
      cmd.go = (state_ff == S_MUL_GO) || (state_ff == S_DIV_GO);
      if (state_ff == S_DIV_GO) begin
         cmd.op = OP_DIV;
         cmd.a  = unit_result;
         cmd.b  = i_ff + FIELD_W'(1);
      end else begin
         cmd.op = OP_MUL;
         cmd.a  = {{(WORK_W-COEF_W){1'b0}}, acc_ff};
         cmd.b  = n_ff - i_ff;
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  n_ff     <= req_n_total;
                  k_ff     <= req_k_chosen;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               acc_ff <= COEF_W'(1);
               i_ff   <= '0;
               m_ff   <= ({1'b0, k_ff} + {1'b0, k_ff} > {1'b0, n_ff}) ? n_ff - k_ff : k_ff;
               if (n_ff > MAX_N) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_coef_ff  <= '0;
                  rsp_ovf_ff   <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (k_ff > n_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_coef_ff  <= '0;
                  rsp_ovf_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_LOOP;
               end
            end
            S_LOOP: begin
               if (i_ff == m_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_coef_ff  <= acc_ff;
                  rsp_ovf_ff   <= 1'b0;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_MUL_GO;
               end
            end
            S_MUL_GO: begin
               state_ff <= S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
               if (unit_done) begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               // exact division: quotient is C(n, i + 1)
               if (unit_done) begin
                  acc_ff   <= unit_result[COEF_W-1:0];
                  i_ff     <= i_ff + FIELD_W'(1);
                  state_ff <= S_LOOP;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // Checks
   `BCU_ASSERT_NOW(a_ovf_zero, clock, reset, rsp_valid && rsp_overflow, rsp_coefficient == '0, "overflow result carries a nonzero coefficient")
   `BCU_ASSERT_NOW(a_idle_on_rsp, clock, reset, rsp_valid, !busy, "result strobe while still busy")
   `BCU_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `BCU_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")

endmodule

`default_nettype wire
